[rtl/mecanum_wheel_command_framer_top_macros.svh]
// Assertion helpers for the wheel command framer.
`ifndef MECANUM_WHEEL_COMMAND_FRAMER_TOP_MACROS_SVH
`define MECANUM_WHEEL_COMMAND_FRAMER_TOP_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define MWCF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mwcf check failed");

// Next-cycle implication.
`define MWCF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mwcf check failed");

`endif

[rtl/mwcf_pkg.sv]
`timescale 1ns / 1ps
package mwcf_pkg;
    localparam int NumWheels = 4;
    localparam int FrameLen  = 15;
    localparam logic [15:0] MaxSpeedRst = 16'd2048;
    localparam logic [15:0] LinGainRst  = 16'd8555;
    localparam logic [15:0] RotGainRst  = 16'd2994;

    localparam logic [1:0] RegMaxSpeed = 2'd0;
    localparam logic [1:0] RegLinGain  = 2'd1;
    localparam logic [1:0] RegRotGain  = 2'd2;

    localparam logic [7:0] DirReverse = 8'h0b;
    localparam logic [7:0] DirForward = 8'h0f;
    localparam logic [7:0] DirStop    = 8'h00;

    // wheel speed width: (17b x 16b) + (16b x 16b) -> 35 bits signed
    localparam int WheelW = 35;
    localparam int MagW   = 34;

    typedef logic signed [WheelW-1:0] t_wheel;
    typedef logic [MagW-1:0] t_mag;

    // one classified command passed from front to back
    typedef struct packed {
        t_wheel [NumWheels-1:0] wheel;
        t_mag                   denom;
    } t_cmd;

    // frame byte select
    function automatic logic [7:0] frame_const(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'hcd;
            4'd1:    b = 8'heb;
            4'd2:    b = 8'hd7;
            4'd3:    b = 8'h02;
            4'd4:    b = 8'h74;
            4'd13:   b = 8'h0d;
            4'd14:   b = 8'h0a;
            default: b = 8'h00;
        endcase
        return b;
    endfunction
endpackage

[rtl/mecanum_wheel_command_framer_top.sv]
`timescale 1ns / 1ps
// Mecanum wheel command framer. A command is taken when i_start is high
// and o_busy low; with base_ready set it yields a 15-byte frame, one byte
// per cycle on o_frame_byte marked by o_strobe, o_last_byte on the 0x0a
// byte. The receiver cannot stall. A command passes the front's multiply,
// sum and maximum stages to the queue; the back end then divides for the
// 4 wheels (7 quotient bits each), sends the frame and returns to idle to
// pop the next, taking no new command until then. o_busy is high while the
// queue is full, while a command is still in the front pipeline, or while
// the queue holds a command that the busy back end has not yet taken.
module mecanum_wheel_command_framer_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic signed [15:0] i_forward_velocity,
    input  logic signed [15:0] i_lateral_velocity,
    input  logic signed [15:0] i_yaw_rate,
    input  logic               i_base_ready,
    output logic               o_strobe,
    output logic [7:0]         o_frame_byte,
    output logic               o_last_byte,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import mwcf_pkg::*;

    logic [15:0] r_max_speed, r_lin_gain, r_rot_gain;
    logic take, f_valid, f_busy, q_empty, q_full, pop, b_busy;
    t_cmd f_cmd, q_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed <= MaxSpeedRst;
            r_lin_gain  <= LinGainRst;
            r_rot_gain  <= RotGainRst;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                RegMaxSpeed: r_max_speed <= pwdata[15:0];
                RegLinGain:  r_lin_gain  <= pwdata[15:0];
                RegRotGain:  r_rot_gain  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            RegMaxSpeed: prdata = {16'd0, r_max_speed};
            RegLinGain:  prdata = {16'd0, r_lin_gain};
            RegRotGain:  prdata = {16'd0, r_rot_gain};
            default:     prdata = 32'd0;
        endcase
    end
    assign pready = 1'b1;

    // hold off while anything in flight could find the queue full
    assign o_busy = q_full || f_busy || (!q_empty && b_busy);
    assign take   = i_start && !o_busy;

    mwcf_front u_front (
        .i_clk, .i_rst_n, .i_take(take),
        .i_forward_velocity, .i_lateral_velocity, .i_yaw_rate, .i_base_ready,
        .i_max_wheel_speed(r_max_speed), .i_linear_gain(r_lin_gain),
        .i_rotation_gain(r_rot_gain),
        .o_valid(f_valid), .o_cmd(f_cmd), .o_busy(f_busy)
    );

    mwcf_fifo u_fifo (
        .i_clk, .i_rst_n, .i_push(f_valid), .i_cmd(f_cmd), .i_pop(pop),
        .o_empty(q_empty), .o_full(q_full), .o_cmd(q_cmd)
    );

    mwcf_back u_back (
        .i_clk, .i_rst_n, .i_empty(q_empty), .i_cmd(q_cmd), .o_pop(pop),
        .o_strobe, .o_frame_byte, .o_last_byte, .o_busy(b_busy)
    );
endmodule

[rtl/mwcf_front.sv]
`timescale 1ns / 1ps
// Front end: computes the four wheel speeds and the percent denominator.
// Stage 1 multiplies, stage 2 sums, stage 3 finds the largest magnitude.
module mwcf_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic signed [15:0]   i_forward_velocity,
    input  logic signed [15:0]   i_lateral_velocity,
    input  logic signed [15:0]   i_yaw_rate,
    input  logic                 i_base_ready,
    input  logic [15:0]          i_max_wheel_speed,
    input  logic [15:0]          i_linear_gain,
    input  logic [15:0]          i_rotation_gain,
    output logic                 o_valid,
    output mwcf_pkg::t_cmd       o_cmd,
    output logic                 o_busy
);
    import mwcf_pkg::*;

    logic r_v1, r_v2, r_v3;
    logic signed [33:0] r_diff, r_sum;
    logic signed [32:0] r_rot;
    t_wheel [NumWheels-1:0] r_w2, r_w3;
    t_mag r_floor2, r_d3;
    t_mag m0, m1, m2, m3, mx;

    logic signed [16:0] s_d, s_s;
    always_comb begin
        s_d = 17'(i_forward_velocity) - 17'(i_lateral_velocity);
        s_s = 17'(i_forward_velocity) + 17'(i_lateral_velocity);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_take && i_base_ready;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_diff <= 34'(s_d * $signed({1'b0, i_linear_gain}));
        r_sum  <= 34'(s_s * $signed({1'b0, i_linear_gain}));
        r_rot  <= 33'(i_yaw_rate * $signed({1'b0, i_rotation_gain}));
        r_w2[0] <= WheelW'(r_diff) - WheelW'(r_rot);
        r_w2[1] <= WheelW'(r_sum) + WheelW'(r_rot);
        r_w2[2] <= WheelW'(r_diff) + WheelW'(r_rot);
        r_w2[3] <= WheelW'(r_sum) - WheelW'(r_rot);
        r_floor2 <= {6'd0, i_max_wheel_speed, 12'd0};
        r_w3 <= r_w2;
        r_d3 <= mx;
    end

    always_comb begin
        m0 = MagW'(r_w2[0][WheelW-1] ? -r_w2[0] : r_w2[0]);
        m1 = MagW'(r_w2[1][WheelW-1] ? -r_w2[1] : r_w2[1]);
        m2 = MagW'(r_w2[2][WheelW-1] ? -r_w2[2] : r_w2[2]);
        m3 = MagW'(r_w2[3][WheelW-1] ? -r_w2[3] : r_w2[3]);
        mx = r_floor2;
        if (m0 > mx) mx = m0;
        if (m1 > mx) mx = m1;
        if (m2 > mx) mx = m2;
        if (m3 > mx) mx = m3;
    end

    assign o_valid    = r_v3;
    assign o_cmd.wheel = r_w3;
    assign o_cmd.denom = r_d3;
    assign o_busy     = r_v1 || r_v2 || r_v3;
endmodule

[rtl/mwcf_fifo.sv]
`timescale 1ns / 1ps
`include "mecanum_wheel_command_framer_top_macros.svh"
// Two-entry command queue between front and back.
module mwcf_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mwcf_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_empty,
    output logic           o_full,
    output mwcf_pkg::t_cmd o_cmd
);
    import mwcf_pkg::*;

    t_cmd r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) r_mem[r_wp] <= i_cmd;
    end

    assign o_cmd   = r_mem[r_rp];
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);

    `MWCF_ASSERT_IMP(a_no_overflow, o_full, !i_push)
    `MWCF_ASSERT_IMP(a_no_underflow, o_empty, !i_pop)
    `MWCF_ASSERT_IMP(a_cnt_range, 1'b1, r_cnt != 2'd3)
endmodule

[rtl/mwcf_back.sv]
`timescale 1ns / 1ps
`include "mecanum_wheel_command_framer_top_macros.svh"
// Back end: divides each wheel by the denominator (restoring, one
// quotient bit per cycle, 7 bits), then serializes the 15-byte frame.
module mwcf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  mwcf_pkg::t_cmd i_cmd,
    output logic           o_pop,
    output logic           o_strobe,
    output logic [7:0]     o_frame_byte,
    output logic           o_last_byte,
    output logic           o_busy
);
    import mwcf_pkg::*;

    localparam logic [1:0] StIdle = 2'd0;
    localparam logic [1:0] StDiv  = 2'd1;
    localparam logic [1:0] StSend = 2'd2;

    logic [1:0] r_state, n_state;
    logic [1:0] r_wheel;
    logic [2:0] r_bit;
    logic [3:0] r_idx;
    t_cmd r_cmd;
    logic [MagW+7:0] r_rem;     // magnitude * 100, reduced per quotient bit
    logic [6:0] r_q;
    logic [NumWheels-1:0][6:0] r_pct;
    logic [NumWheels-1:0] r_neg;

    logic [MagW+7:0] trial;
    logic cur_neg;
    logic [6:0] q_next;
    logic [6:0] pct_sel;

    always_comb begin
        case (r_wheel)
            2'd0:    cur_neg = r_cmd.wheel[0][WheelW-1];
            2'd1:    cur_neg = r_cmd.wheel[1][WheelW-1];
            2'd2:    cur_neg = r_cmd.wheel[2][WheelW-1];
            default: cur_neg = r_cmd.wheel[3][WheelW-1];
        endcase
        // quotient bit r_bit: compare remainder against denom << r_bit
        trial = (MagW+8)'({8'd0, r_cmd.denom} << r_bit);
        q_next = r_q;
        if (r_rem >= trial) q_next[r_bit] = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
        end else begin
            r_state <= n_state;
        end
        case (r_state)
            StIdle: begin
                r_cmd <= i_cmd;
                r_wheel <= 2'd0;
                r_bit <= 3'd6;
                r_q <= '0;
                r_rem <= (MagW+8)'({8'd0,
                    MagW'(i_cmd.wheel[0][WheelW-1] ? -i_cmd.wheel[0] : i_cmd.wheel[0])}
                    * 8'd100);
            end
            StDiv: begin
                r_idx <= 4'd0;
                if (r_bit == 3'd0) begin
                    // magnitude quotient never exceeds 100 since |w| <= denom
                    r_pct[r_wheel] <= (r_cmd.denom == '0) ? 7'd0 : q_next;
                    r_neg[r_wheel] <= cur_neg;
                    r_wheel <= r_wheel + 2'd1;
                    r_bit <= 3'd6;
                    r_q <= '0;
                    case (r_wheel)
                        2'd0: r_rem <= (MagW+8)'({8'd0, MagW'(r_cmd.wheel[1][WheelW-1]
                            ? -r_cmd.wheel[1] : r_cmd.wheel[1])} * 8'd100);
                        2'd1: r_rem <= (MagW+8)'({8'd0, MagW'(r_cmd.wheel[2][WheelW-1]
                            ? -r_cmd.wheel[2] : r_cmd.wheel[2])} * 8'd100);
                        default: r_rem <= (MagW+8)'({8'd0, MagW'(r_cmd.wheel[3][WheelW-1]
                            ? -r_cmd.wheel[3] : r_cmd.wheel[3])} * 8'd100);
                    endcase
                end else begin
                    r_q <= q_next;
                    if (r_rem >= trial) r_rem <= r_rem - trial;
                    r_bit <= r_bit - 3'd1;
                end
            end
            StSend: r_idx <= r_idx + 4'd1;
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            StIdle:  if (!i_empty) n_state = StDiv;
            StDiv:   if (r_bit == 3'd0 && r_wheel == 2'd3) n_state = StSend;
            StSend:  if (r_idx == 4'(FrameLen-1)) n_state = StIdle;
            default: n_state = StIdle;
        endcase
    end

    assign o_pop = (r_state == StIdle) && !i_empty;

    always_comb begin
        pct_sel = r_pct[r_idx[1:0] - 2'd1];
        o_frame_byte = frame_const(r_idx);
        if (r_idx >= 4'd5 && r_idx <= 4'd8) begin
            if (r_pct[r_idx[1:0] - 2'd1] == 7'd0) o_frame_byte = DirStop;
            else if (r_neg[r_idx[1:0] - 2'd1]) o_frame_byte = DirReverse;
            else o_frame_byte = DirForward;
        end else if (r_idx >= 4'd9 && r_idx <= 4'd12) begin
            o_frame_byte = {1'b0, pct_sel};
        end
    end

    assign o_strobe    = (r_state == StSend);
    assign o_last_byte = o_strobe && (r_idx == 4'(FrameLen-1));
    assign o_busy      = (r_state != StIdle);

    `MWCF_ASSERT_IMP(a_pct_range, o_strobe && r_idx == 4'd9, r_pct[0] <= 7'd100)
    `MWCF_ASSERT_NXT(a_last_idle, o_last_byte, r_state == StIdle)
    `MWCF_ASSERT_IMP(a_pop_idle, o_pop, r_state == StIdle)
endmodule
